// File: src/drive_history_shift_store_unit_assert.svh
// Assertion macros for the drive history shift store.
// Included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef DRIVE_HISTORY_SHIFT_STORE_UNIT_ASSERT_SVH
`define DRIVE_HISTORY_SHIFT_STORE_UNIT_ASSERT_SVH

// same-cycle implication
`define DHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dhs_pkg.sv
// Package for the drive history shift store: codes, entry and search types.
// No dependencies.
package dhs_pkg;

    localparam int FUNC_W = 3;
    localparam int DIR_W  = 3;
    localparam int DIST_W = 24;

    typedef logic [FUNC_W-1:0]        t_func;
    typedef logic [DIR_W-1:0]         t_dir;
    typedef logic signed [DIST_W-1:0] t_dist;

    localparam t_func FUNC_PUSH   = 3'd0;
    localparam t_func FUNC_POP    = 3'd1;
    localparam t_func FUNC_UPDATE = 3'd2;
    localparam t_func FUNC_CLEAR  = 3'd3;

    localparam t_dir DIR_FORWARD = 3'd0;
    localparam t_dir DIR_ROT_CW  = 3'd2;
    localparam t_dir DIR_ROT_CCW = 3'd3;
    localparam t_dir DIR_NONE    = 3'd5;

    localparam logic [1:0] ROT_DEFAULT = 2'd3;

    typedef struct packed {
        t_dir  dir;
        t_dist distance;
    } t_entry;

    typedef struct packed {
        logic shift_prev;
        logic shift_next;
        logic load_dist;
        logic clear;
    } t_cell_op;

    typedef struct packed {
        logic       rot_seen;
        logic [1:0] rot;
        logic [1:0] nfwd;
        t_dist      fwd0;
        t_dist      fwd1;
        t_dist      fwd2;
    } t_search;

endpackage

// File: src/dhs_in_if.sv
// Command channel of the drive history shift store: valid, ready, operation and move.
// Depends on dhs_pkg.
interface dhs_in_if;
    logic               valid;
    logic               ready;
    dhs_pkg::t_func     func;
    dhs_pkg::t_dir      move_direction;
    dhs_pkg::t_dist     move_distance;

    modport source (output valid, output func, output move_direction, output move_distance,
                    input ready);
    modport sink   (input valid, input func, input move_direction, input move_distance,
                    output ready);
endinterface

// File: src/dhs_out_if.sv
// Result channel of the drive history shift store: valid, ready, rotate and forward data.
// Depends on dhs_pkg.
interface dhs_out_if;
    logic           valid;
    logic           ready;
    logic [1:0]     last_rotate;
    logic [1:0]     forward_found;
    dhs_pkg::t_dist forward_dist_first;
    dhs_pkg::t_dist forward_dist_second;
    dhs_pkg::t_dist forward_dist_third;

    modport source (output valid, output last_rotate, output forward_found,
                    output forward_dist_first, output forward_dist_second,
                    output forward_dist_third, input ready);
    modport sink   (input valid, input last_rotate, input forward_found,
                    input forward_dist_first, input forward_dist_second,
                    input forward_dist_third, output ready);
endinterface

// File: src/dhs_cell.sv
// One store cell: holds a move, shifts with its neighbors, and passes the search wave on.
// Depends on dhs_pkg.
module dhs_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dhs_pkg::t_cell_op i_op,
    input  dhs_pkg::t_entry  i_prev,
    input  dhs_pkg::t_entry  i_next,
    output dhs_pkg::t_entry  o_entry,
    input  dhs_pkg::t_search i_srch,
    input  logic             i_srch_valid,
    input  logic             i_hold,
    output dhs_pkg::t_search o_srch,
    output logic             o_srch_valid
);
    import dhs_pkg::*;

    t_entry  r_entry, n_entry;
    t_search r_srch, n_srch;
    logic    r_srch_valid, n_srch_valid;

    always_comb begin
        n_entry = r_entry;
        priority if (i_op.clear) begin
            n_entry.dir      = DIR_NONE;
            n_entry.distance = '0;
        end else if (i_op.shift_prev) begin
            n_entry = i_prev;
        end else if (i_op.shift_next) begin
            n_entry = i_next;
        end else if (i_op.load_dist) begin
            n_entry.distance = i_prev.distance;
        end else begin
            n_entry = r_entry;
        end
    end

    always_comb begin
        n_srch = i_srch;
        if (!i_srch.rot_seen && (r_entry.dir == DIR_ROT_CW || r_entry.dir == DIR_ROT_CCW)) begin
            n_srch.rot      = r_entry.dir[1:0];
            n_srch.rot_seen = 1'b1;
        end
        if (r_entry.dir == DIR_FORWARD) begin
            unique case (i_srch.nfwd)
                2'd0: begin
                    n_srch.fwd0 = r_entry.distance;
                    n_srch.nfwd = 2'd1;
                end
                2'd1: begin
                    n_srch.fwd1 = r_entry.distance;
                    n_srch.nfwd = 2'd2;
                end
                2'd2: begin
                    n_srch.fwd2 = r_entry.distance;
                    n_srch.nfwd = 2'd3;
                end
                default: n_srch.nfwd = i_srch.nfwd;
            endcase
        end
        n_srch_valid = i_srch_valid || (i_hold && r_srch_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.dir      <= DIR_NONE;
            r_entry.distance <= '0;
            r_srch_valid     <= 1'b0;
        end else begin
            r_entry      <= n_entry;
            r_srch_valid <= n_srch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_srch_valid) begin
            r_srch <= n_srch;
        end
    end

    assign o_entry      = r_entry;
    assign o_srch       = r_srch;
    assign o_srch_valid = r_srch_valid;

endmodule

// File: src/drive_history_shift_store_unit.sv
// Top level of the drive history shift store: a chain of DEPTH cells plus result register.
// Depends on dhs_pkg, dhs_in_if, dhs_out_if, dhs_cell and the assertion header.
//
//  channel | role   | handshake     | payload
//  i_cmd   | sink   | valid/ready   | func, move_direction, move_distance
//  o_res   | source | valid/ready   | last_rotate, forward_found, forward_dist_first..third
//
// For each item the store updates at the accepting edge, then a search wave walks the cell
// chain one cell per cycle, then the result register loads once the output is free.
// One item is in flight at a time; the next is accepted once the result is registered.
// A stalled result holds in the output register, and a second finished wave waits in the
// tail cell. Reset is synchronous and sets every entry to direction none, distance 0.
`include "drive_history_shift_store_unit_assert.svh"

module drive_history_shift_store_unit #(
    parameter int DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dhs_in_if.sink   i_cmd,
    dhs_out_if.source o_res
);
    import dhs_pkg::*;

    logic r_busy, n_busy;
    logic r_start;
    logic r_out_valid, n_out_valid;
    logic [1:0] r_last_rotate;
    logic [1:0] r_forward_found;
    t_dist r_dist_first, r_dist_second, r_dist_third;

    logic accept, take, tail_hold;
    t_entry   head_in, tail_in;
    t_search  srch_init;
    t_entry   w_entry [DEPTH];
    t_search  w_srch  [DEPTH];
    logic [DEPTH-1:0] w_srch_valid;
    t_search  tail_srch;

    assign accept      = i_cmd.valid && !r_busy;
    assign i_cmd.ready = !r_busy;

    assign head_in.dir      = i_cmd.move_direction;
    assign head_in.distance = i_cmd.move_distance;
    assign tail_in.dir      = DIR_NONE;
    assign tail_in.distance = '0;

    assign srch_init.rot_seen = 1'b0;
    assign srch_init.rot      = ROT_DEFAULT;
    assign srch_init.nfwd     = 2'd0;
    assign srch_init.fwd0     = '0;
    assign srch_init.fwd1     = '0;
    assign srch_init.fwd2     = '0;

    assign tail_srch = w_srch[DEPTH-1];
    assign take      = w_srch_valid[DEPTH-1] && (!r_out_valid || o_res.ready);
    assign tail_hold = w_srch_valid[DEPTH-1] && !take;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_op op;
        t_entry   prev, next;
        t_search  srch_in;
        logic     srch_in_valid;
        logic     hold;

        assign op.shift_prev = accept && (i_cmd.func == FUNC_PUSH);
        assign op.shift_next = accept && (i_cmd.func == FUNC_POP);
        assign op.clear      = accept && (i_cmd.func == FUNC_CLEAR);

        if (k == 0) begin : g_head
            assign op.load_dist    = accept && (i_cmd.func == FUNC_UPDATE);
            assign prev            = head_in;
            assign srch_in         = srch_init;
            assign srch_in_valid   = r_start;
        end else begin : g_body
            assign op.load_dist    = 1'b0;
            assign prev            = w_entry[k-1];
            assign srch_in         = w_srch[k-1];
            assign srch_in_valid   = w_srch_valid[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign next = tail_in;
            assign hold = tail_hold;
        end else begin : g_mid
            assign next = w_entry[k+1];
            assign hold = 1'b0;
        end

        dhs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (op),
            .i_prev       (prev),
            .i_next       (next),
            .o_entry      (w_entry[k]),
            .i_srch       (srch_in),
            .i_srch_valid (srch_in_valid),
            .i_hold       (hold),
            .o_srch       (w_srch[k]),
            .o_srch_valid (w_srch_valid[k])
        );
    end

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (take) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid && !o_res.ready;
        if (take) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_start     <= accept;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_last_rotate   <= tail_srch.rot;
            r_forward_found <= tail_srch.nfwd[1] ? tail_srch.nfwd : 2'd0;
            r_dist_first    <= tail_srch.fwd0;
            r_dist_second   <= tail_srch.fwd1;
            r_dist_third    <= tail_srch.fwd2;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.last_rotate         = r_last_rotate;
    assign o_res.forward_found       = r_forward_found;
    assign o_res.forward_dist_first  = r_dist_first;
    assign o_res.forward_dist_second = r_dist_second;
    assign o_res.forward_dist_third  = r_dist_third;

    `DHS_ASSERT_NOW(a_single_wave, 1'b1, $onehot0(w_srch_valid), "more than one search wave")
    `DHS_ASSERT_NOW(a_busy_has_wave, r_busy, r_start || (|w_srch_valid), "busy with no wave")
    `DHS_ASSERT_NEXT(a_take_frees, take, r_out_valid && !r_busy, "result load did not free")
    `DHS_ASSERT_NOW(a_start_busy, r_start, r_busy && !(|w_srch_valid), "wave start while idle")

endmodule
